### rtl/core/cror_pkg.sv
// Shared types and constants for the chained range-offset remapper.
package cror_pkg;

    // Slot field of a write beat is six bits wide.
    localparam int SLOT_SPAN = 64;
    // Holds a stage count up to the largest stage parameter plus one.
    localparam int CNT_W = 5;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_MAP   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_APPLY,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] src;
        logic [31:0] len;
    } t_entry;

    typedef struct packed {
        logic rd_en;
        logic best_clr;
    } t_scan_ctl;

    typedef struct packed {
        logic        found;
        logic [31:0] src;
        logic [31:0] dest;
    } t_scan_res;

endpackage

### rtl/core/chained_range_offset_remap.sv
// Map beat: each stage in use reads min(ENTRIES_PER_STAGE, 64) entries, one table read per cycle,
// then drains the last read and applies the best match. Default size: 8 stages of 64 entries.
// Write and clear beats leave the block idle; no other beat is taken while a map runs.
// Reset (synchronous, active low) sweeps the table to zero, one entry a cycle, over all
// STAGE_COUNT * 2**ceil(log2(entries scanned)) entries (512 by default), input stalled.
// Reset also sets the running minimum to all ones and the stage count (r_cfg) to 7.
module chained_range_offset_remap #(
    parameter int STAGE_COUNT       = 8,
    parameter int ENTRIES_PER_STAGE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [2:0]  i_stage_index,
    input  logic [5:0]  i_slot_index,
    input  logic [31:0] i_dest_base,
    input  logic [31:0] i_source_base,
    input  logic [31:0] i_range_length,
    input  logic [31:0] i_value_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_mapped_value,
    output logic [31:0] o_lowest_so_far
);

    localparam int SCAN  = (ENTRIES_PER_STAGE < cror_pkg::SLOT_SPAN) ?
                           ENTRIES_PER_STAGE : cror_pkg::SLOT_SPAN;
    localparam int EW    = (SCAN > 1) ? $clog2(SCAN) : 1;
    localparam int SW    = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam int AW    = SW + EW;
    localparam int DEPTH = STAGE_COUNT * (2 ** EW);

    cror_pkg::t_state    r_state, n_state;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic [SW-1:0]       r_stage, n_stage;
    logic [EW-1:0]       r_slot, n_slot;
    logic [31:0]         r_value, n_value;
    logic [3:0]          r_cfg;
    logic [31:0]         r_min, n_min;
    logic                r_out_valid, n_out_valid;
    logic [31:0]         r_out_value, n_out_value;
    logic [31:0]         r_out_low, n_out_low;

    logic                in_accept;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    cror_pkg::t_entry    wr_entry;
    cror_pkg::t_scan_ctl ctl;
    cror_pkg::t_scan_res res;
    logic [cror_pkg::CNT_W-1:0] eff_stages;
    logic                last_stage;
    logic                write_ok;
    logic [31:0]         mapped;
    logic [31:0]         new_min;

    cror_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_rd_addr  ({r_stage, r_slot}),
        .i_ctl      (ctl),
        .i_value    (r_value),
        .o_res      (res)
    );

    assign o_in_stall      = (r_state != cror_pkg::S_IDLE);
    assign in_accept       = i_in_valid && !o_in_stall;
    assign o_out_valid     = r_out_valid;
    assign o_mapped_value  = r_out_value;
    assign o_lowest_so_far = r_out_low;

    // Saturate the stage count at the number of stages built.
    assign eff_stages = (32'(r_cfg) > STAGE_COUNT) ? cror_pkg::CNT_W'(STAGE_COUNT)
                                                   : cror_pkg::CNT_W'(r_cfg);
    assign last_stage = (cror_pkg::CNT_W'(r_stage) + cror_pkg::CNT_W'(1)) == eff_stages;
    assign write_ok   = (32'(i_stage_index) < STAGE_COUNT) && (32'(i_slot_index) < SCAN);
    assign mapped     = res.found ? (r_value - res.src + res.dest) : r_value;
    assign new_min    = (r_value < r_min) ? r_value : r_min;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_stage     = r_stage;
        n_slot      = r_slot;
        n_value     = r_value;
        n_min       = r_min;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_value = r_out_value;
        n_out_low   = r_out_low;
        wr_en       = 1'b0;
        wr_addr     = r_clr_addr;
        wr_entry    = '0;
        ctl         = '0;
        case (r_state)
            cror_pkg::S_CLEAR: begin
                wr_en      = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = cror_pkg::S_IDLE;
                end
            end
            cror_pkg::S_IDLE: begin
                if (in_accept) begin
                    case (cror_pkg::t_cmd'(i_cmd))
                        cror_pkg::CMD_WRITE: begin
                            wr_en         = write_ok;
                            wr_addr       = {SW'(i_stage_index), EW'(i_slot_index)};
                            wr_entry.dest = i_dest_base;
                            wr_entry.src  = i_source_base;
                            wr_entry.len  = i_range_length;
                        end
                        cror_pkg::CMD_MAP: begin
                            n_value      = i_value_in;
                            n_stage      = '0;
                            n_slot       = '0;
                            ctl.best_clr = 1'b1;
                            n_state      = (eff_stages == '0) ? cror_pkg::S_OUT
                                                              : cror_pkg::S_SCAN;
                        end
                        cror_pkg::CMD_CLEAR: begin
                            n_min = '1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cror_pkg::S_SCAN: begin
                ctl.rd_en = 1'b1;
                if (r_slot == EW'(SCAN - 1)) begin
                    n_state = cror_pkg::S_DRAIN;
                end else begin
                    n_slot = r_slot + EW'(1);
                end
            end
            cror_pkg::S_DRAIN: begin
                // Let the last read entry reach the compare unit.
                n_state = cror_pkg::S_APPLY;
            end
            cror_pkg::S_APPLY: begin
                n_value = mapped;
                if (last_stage) begin
                    n_state = cror_pkg::S_OUT;
                end else begin
                    n_stage      = r_stage + SW'(1);
                    n_slot       = '0;
                    ctl.best_clr = 1'b1;
                    n_state      = cror_pkg::S_SCAN;
                end
            end
            cror_pkg::S_OUT: begin
                // Hold until the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_min       = new_min;
                    n_out_valid = 1'b1;
                    n_out_value = r_value;
                    n_out_low   = new_min;
                    n_state     = cror_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cror_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cror_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_cfg       <= 4'd7;
            r_min       <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_min       <= n_min;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage     <= n_stage;
        r_slot      <= n_slot;
        r_value     <= n_value;
        r_out_value <= n_out_value;
        r_out_low   <= n_out_low;
    end

endmodule

### rtl/core/cror_table.sv
// Range table memory with a shared range-compare unit and best-match tracking.
module cror_table #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  cror_pkg::t_entry    i_wr_entry,
    input  logic [AW-1:0]       i_rd_addr,
    input  cror_pkg::t_scan_ctl i_ctl,
    input  logic [31:0]         i_value,
    output cror_pkg::t_scan_res o_res
);

    cror_pkg::t_entry r_mem [DEPTH];
    cror_pkg::t_entry r_rd_data;
    logic             r_rd_vld;
    logic             r_found;
    logic [31:0]      r_best_src;
    logic [31:0]      r_best_dest;

    logic [32:0]      diff;
    logic             hit;
    logic             take;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Borrow out of the subtract means value is below source; a zero
    // length can never exceed the offset, so unused entries drop out.
    assign diff = {1'b0, i_value} - {1'b0, r_rd_data.src};
    assign hit  = !diff[32] && (diff[31:0] < r_rd_data.len);
    // Strict compare keeps the lowest slot on equal sources.
    assign take = r_rd_vld && hit && (!r_found || (r_rd_data.src > r_best_src));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_rd_vld <= i_ctl.rd_en;
            if (i_ctl.best_clr) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_src  <= r_rd_data.src;
            r_best_dest <= r_rd_data.dest;
        end
    end

    assign o_res.found = r_found;
    assign o_res.src   = r_best_src;
    assign o_res.dest  = r_best_dest;

endmodule

### bench/chained_range_offset_remap_test.sv
`timescale 1ns / 1ps
// Self-checking regression bench for the chained range-offset remapper.
module chained_range_offset_remap_test;

    localparam int NSTAGE = 8;
    localparam int NSLOT = 64;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int NDIR = 25;
    localparam int NPHASE = 6;
    localparam int PHASE_ITEMS = 115;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES = 600;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  stage;
        logic [5:0]  slot;
        logic [31:0] dest;
        logic [31:0] src;
        logic [31:0] len;
        logic [31:0] value;
    } t_beat;

    typedef struct packed {
        logic [31:0] mapped;
        logic [31:0] lowest;
    } t_remap;

    typedef struct packed {
        t_beat  beat;
        logic   typed;
        t_remap want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [3:0]  i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_cmd;
    logic [2:0]  i_stage_index;
    logic [5:0]  i_slot_index;
    logic [31:0] i_dest_base;
    logic [31:0] i_source_base;
    logic [31:0] i_range_length;
    logic [31:0] i_value_in;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_mapped_value;
    logic [31:0] o_lowest_so_far;

    // Predictor state: tables, running minimum and stage count as the block holds them.
    cror_pkg::t_entry remap_table [NSTAGE][NSLOT];
    logic [31:0]      low_mark;
    logic [3:0]       stage_sel;

    t_remap      expected_remaps [$];
    t_remap      oldest_remap;
    t_row        directed_rows [NDIR];
    int          mismatch_count = 0;
    bit          gaps_on = 1'b1;

    chained_range_offset_remap #(
        .STAGE_COUNT       (NSTAGE),
        .ENTRIES_PER_STAGE (NSLOT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_stage_index   (i_stage_index),
        .i_slot_index    (i_slot_index),
        .i_dest_base     (i_dest_base),
        .i_source_base   (i_source_base),
        .i_range_length  (i_range_length),
        .i_value_in      (i_value_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_mapped_value  (o_mapped_value),
        .o_lowest_so_far (o_lowest_so_far)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("chained_range_offset_remap regression: fail");
        $finish;
    end

    // One stage: the containing entry with the greatest source wins, lowest slot on a tie.
    function automatic logic [31:0] map_stage(input int s, input logic [31:0] v);
        int               k;
        cror_pkg::t_entry e;
        logic [32:0]      top;
        logic             hit;
        logic [31:0]      best_src;
        logic [31:0]      best_dest;
        hit = 1'b0;
        best_src = '0;
        best_dest = '0;
        for (k = 0; k < NSLOT; k++) begin
            e = remap_table[s][k];
            top = {1'b0, e.src} + {1'b0, e.len};
            if (e.len != 0 && v >= e.src && {1'b0, v} < top) begin
                if (!hit || e.src > best_src) begin
                    hit = 1'b1;
                    best_src = e.src;
                    best_dest = e.dest;
                end
            end
        end
        return hit ? v - best_src + best_dest : v;
    endfunction

    function automatic logic [31:0] predict_remap(input logic [31:0] v);
        int          n;
        int          s;
        logic [31:0] r;
        n = (stage_sel > NSTAGE) ? NSTAGE : int'(stage_sel);
        r = v;
        for (s = 0; s < n; s++) begin
            r = map_stage(s, r);
        end
        return r;
    endfunction

    function automatic t_row beat_row(input logic [1:0] cmd, input logic [2:0] st,
                                      input logic [5:0] sl, input logic [31:0] d,
                                      input logic [31:0] s, input logic [31:0] l,
                                      input logic [31:0] v);
        t_row r;
        r.beat = '{cmd, st, sl, d, s, l, v};
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic t_row typed_row(input logic [31:0] v, input logic [31:0] m,
                                       input logic [31:0] lo);
        t_row r;
        r = beat_row(cror_pkg::CMD_MAP, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, v);
        r.typed = 1'b1;
        r.want = '{m, lo};
        return r;
    endfunction

    // Fold an accepted beat into the predictor; a map beat queues its result.
    task automatic track_beat(input t_row r);
        t_remap res;
        case (r.beat.cmd)
            cror_pkg::CMD_WRITE: begin
                remap_table[r.beat.stage][r.beat.slot] = '{r.beat.dest, r.beat.src, r.beat.len};
            end
            cror_pkg::CMD_MAP: begin
                res.mapped = predict_remap(r.beat.value);
                if (res.mapped < low_mark) low_mark = res.mapped;
                res.lowest = low_mark;
                expected_remaps.push_back(r.typed ? r.want : res);
            end
            cror_pkg::CMD_CLEAR: begin
                low_mark = '1;
            end
            default: ;
        endcase
    endtask

    // Called at a rising edge; returns at the edge that accepts the beat.
    task automatic drive_beat(input t_row r);
        while (gaps_on && $urandom_range(99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= r.beat.cmd;
        i_stage_index  <= r.beat.stage;
        i_slot_index   <= r.beat.slot;
        i_dest_base    <= r.beat.dest;
        i_source_base  <= r.beat.src;
        i_range_length <= r.beat.len;
        i_value_in     <= r.beat.value;
        do @(posedge i_clk); while (o_in_stall);
        track_beat(r);
    endtask

    task automatic wait_idle(input int extra);
        i_in_valid <= 1'b0;
        while (expected_remaps.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic set_stage_count(input logic [3:0] n);
        wait_idle(SETTLE_CYCLES);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= n;
        @(posedge i_clk);
        stage_sel = n;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Ranges and values cluster around a few anchors so that chained stages keep hitting.
    task automatic run_random_phase(input int count);
        logic [31:0] anchors [8];
        t_row        r;
        int          done;
        int          pick;
        int          i;
        for (i = 0; i < 8; i++) anchors[i] = $urandom;
        anchors[0] = 32'h0000_0000;
        anchors[7] = 32'hFFFF_FFE0;
        done = 0;
        while (done < count) begin
            r = beat_row(2'($urandom_range(3)), 3'($urandom_range(7)), 6'($urandom_range(63)),
                         $urandom, $urandom, $urandom, $urandom);
            pick = $urandom_range(99);
            if (pick < 42) begin
                r.beat.cmd = cror_pkg::CMD_WRITE;
                r.beat.src = anchors[$urandom_range(7)] + $urandom_range(31);
                r.beat.dest = anchors[$urandom_range(7)] + $urandom_range(31);
                case ($urandom_range(9))
                    0: r.beat.len = '0;
                    1: r.beat.len = $urandom;
                    2: r.beat.len = '1;
                    default: r.beat.len = $urandom_range(48, 1);
                endcase
            end else if (pick < 82) begin
                r.beat.cmd = cror_pkg::CMD_MAP;
                r.beat.value = anchors[$urandom_range(7)] + $urandom_range(40);
            end else if (pick < 88) begin
                r.beat.cmd = cror_pkg::CMD_MAP;
            end else if (pick < 95) begin
                r.beat.cmd = cror_pkg::CMD_CLEAR;
            end else begin
                r.beat.cmd = CMD_UNUSED;
            end
            drive_beat(r);
            if (r.beat.cmd != CMD_UNUSED) done++;
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(99) < 14);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_remaps.size() == 0) begin
                $display("%0t: unexpected result, mapped %h lowest %h",
                         $time, o_mapped_value, o_lowest_so_far);
                mismatch_count++;
            end else begin
                oldest_remap = expected_remaps.pop_front();
                if (o_mapped_value !== oldest_remap.mapped) begin
                    $display("%0t: mapped_value expected %h actual %h",
                             $time, oldest_remap.mapped, o_mapped_value);
                    mismatch_count++;
                end
                if (o_lowest_so_far !== oldest_remap.lowest) begin
                    $display("%0t: lowest_so_far expected %h actual %h",
                             $time, oldest_remap.lowest, o_lowest_so_far);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        logic [3:0] phase_counts [NPHASE];
        int         phase;
        int         s;
        int         k;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_in_valid     = 1'b0;
        i_cmd          = cror_pkg::CMD_WRITE;
        i_stage_index  = '0;
        i_slot_index   = '0;
        i_dest_base    = '0;
        i_source_base  = '0;
        i_range_length = '0;
        i_value_in     = '0;
        for (s = 0; s < NSTAGE; s++) begin
            for (k = 0; k < NSLOT; k++) remap_table[s][k] = '0;
        end
        low_mark = '1;
        stage_sel = 4'd7;
        phase_counts = '{4'd8, 4'd0, 4'd1, 4'd15, 4'd2, 4'($urandom_range(7, 3))};

        directed_rows = '{
            // empty tables pass values through; minimum starts at all ones
            typed_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
            typed_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000),
            beat_row(cror_pkg::CMD_CLEAR, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0),
            typed_row(32'h0000_1234, 32'h0000_1234, 32'h0000_1234),
            // an unused command must not store its entry
            beat_row(CMD_UNUSED, 3'd0, 6'd1, 32'hAAAA_0000, 32'd0, 32'hFFFF_FFFF, 32'd0),
            beat_row(cror_pkg::CMD_MAP, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd77),
            beat_row(cror_pkg::CMD_WRITE, 3'd0, 6'd0, 32'd100, 32'd10, 32'd5, 32'hFFFF_FFFF),
            beat_row(cror_pkg::CMD_MAP, 3'd7, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'd10),
            beat_row(cror_pkg::CMD_MAP, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd14),
            beat_row(cror_pkg::CMD_MAP, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd15),
            beat_row(cror_pkg::CMD_MAP, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd9),
            // range end beyond 2^32 must not wrap
            beat_row(cror_pkg::CMD_WRITE, 3'd0, 6'd63, 32'd0, 32'hFFFF_FFF0,
                     32'hFFFF_FFFF, 32'd0),
            beat_row(cror_pkg::CMD_MAP, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF),
            // overlap: greater source wins, and the result wraps to zero
            beat_row(cror_pkg::CMD_WRITE, 3'd0, 6'd5, 32'hFFFF_FFFF, 32'd12, 32'd2, 32'd0),
            beat_row(cror_pkg::CMD_MAP, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd13),
            // same source: lower slot wins
            beat_row(cror_pkg::CMD_WRITE, 3'd0, 6'd6, 32'd7, 32'd12, 32'd100, 32'd0),
            beat_row(cror_pkg::CMD_MAP, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd12),
            beat_row(cror_pkg::CMD_MAP, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd60),
            // zero length never matches
            beat_row(cror_pkg::CMD_WRITE, 3'd1, 6'd0, 32'd55, 32'd0, 32'd0, 32'd0),
            beat_row(cror_pkg::CMD_MAP, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0),
            // last stage stays out of the chain while the count is seven
            beat_row(cror_pkg::CMD_WRITE, 3'd7, 6'd31, 32'hDEAD_BEEF, 32'd0,
                     32'hFFFF_FFFF, 32'd0),
            beat_row(cror_pkg::CMD_MAP, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd1000),
            beat_row(cror_pkg::CMD_WRITE, 3'd3, 6'd2, 32'd0, 32'h0000_1000,
                     32'h7FFF_FFFF, 32'd0),
            beat_row(cror_pkg::CMD_MAP, 3'd0, 6'd0, 32'd0, 32'd0, 32'd0, 32'h4000_0000),
            beat_row(cror_pkg::CMD_CLEAR, 3'd7, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) drive_beat(directed_rows[i]);

        for (phase = 0; phase < NPHASE; phase++) begin
            set_stage_count(phase_counts[phase]);
            // keep one whole phase free of gaps and stalls
            gaps_on <= (phase != 3);
            run_random_phase(PHASE_ITEMS);
        end

        wait_idle(TAIL_CYCLES);
        if (mismatch_count == 0 && expected_remaps.size() == 0) begin
            $display("chained_range_offset_remap regression: pass");
        end else begin
            $display("chained_range_offset_remap regression: fail");
        end
        $finish;
    end

endmodule
